>>> rtl/csbm_pkg.sv
// Shared types, constants and helpers for the Caesar shift search decoder.
`timescale 1ns / 1ps

package csbm_pkg;

    localparam int MAX_LEN_DEF     = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int ALPHA  = 52;
    localparam int BIN_W  = 6;
    localparam int CHAR_W = 8;
    localparam int HIST_W = 7;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    localparam logic [HIST_W-1:0] HIST_SAT  = 7'd127;
    localparam logic [BIN_W-1:0]  BIN_LAST  = 6'd51;
    localparam logic [BIN_W-1:0]  SCAN_DONE = 6'd52;
    localparam logic [BIN_W-1:0]  HALF_ALPHA = 6'd26;

    localparam logic [CHAR_W-1:0] CHR_UA = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_UZ = 8'h5A;
    localparam logic [CHAR_W-1:0] CHR_LA = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LZ = 8'h7A;

    // command codes on the input tuser
    localparam logic [FUNC_W-1:0] FN_CIPHER = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REF    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_END    = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_CHAR = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LENGTH   = 2'd2;

    // classified command between front end and engine
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              is_letter;
        logic [BIN_W-1:0]  idx;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_REF_HIST,
        BK_REF_WR,
        BK_END,
        BK_SCAN,
        BK_EMIT_RD,
        BK_EMIT_OUT
    } bk_state_t;

    // reduce a sum below 2*ALPHA into 0..ALPHA-1
    function automatic logic [BIN_W-1:0] mod_alpha(input logic [BIN_W:0] v);
        logic [BIN_W:0] r;
        r = (v >= (BIN_W+1)'(ALPHA)) ? v - (BIN_W+1)'(ALPHA) : v;
        return r[BIN_W-1:0];
    endfunction

    // letter index back to ASCII
    function automatic logic [CHAR_W-1:0] index_char(input logic [BIN_W-1:0] k);
        logic [CHAR_W-1:0] r;
        r = (k < HALF_ALPHA) ? CHR_UA + CHAR_W'(k)
                             : CHR_LA + CHAR_W'(k) - CHAR_W'(HALF_ALPHA);
        return r;
    endfunction

endpackage

>>> rtl/csbm_front.sv
// Front end: takes input words, classifies the character, queues a command.
`timescale 1ns / 1ps

module csbm_front import csbm_pkg::*; (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // [7:0] in_char
    input  logic [FUNC_W-1:0] s_tuser,   // [1:0] func
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd
);

    logic is_upper;
    logic is_lower;

    assign is_upper = (s_tdata >= CHR_UA) && (s_tdata <= CHR_UZ);
    assign is_lower = (s_tdata >= CHR_LA) && (s_tdata <= CHR_LZ);

    assign s_tready = !q_full;

    // unused code 3 is taken and dropped here
    assign q_push = s_tvalid && !q_full &&
                    ((s_tuser == FN_CIPHER) || (s_tuser == FN_REF) || (s_tuser == FN_END));

    always_comb begin
        q_cmd.func      = s_tuser;
        q_cmd.is_letter = is_upper || is_lower;
        if (is_upper) begin
            q_cmd.idx = BIN_W'(s_tdata - CHR_UA);
        end else if (is_lower) begin
            q_cmd.idx = BIN_W'(s_tdata - CHR_LA + CHAR_W'(HALF_ALPHA));
        end else begin
            q_cmd.idx = '0;
        end
    end

endmodule

>>> rtl/csbm_fifo.sv
// Command queue between the front end and the engine.
`timescale 1ns / 1ps

module csbm_fifo import csbm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/csbm_back.sv
// Engine: cipher store, shift histogram, best-shift scan and result output.
`timescale 1ns / 1ps

module csbm_back import csbm_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,   // [7:0] out_char
    output logic [STAT_W-1:0] m_tuser,   // [1:0] status
    output logic              m_tlast
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    bk_state_t state_reg, state_next;

    logic [LEN_W-1:0]  cipher_len_reg, cipher_len_next;
    logic [LEN_W-1:0]  ref_len_reg, ref_len_next;
    logic              bad_reg, bad_next;
    logic              ovf_reg, ovf_next;
    logic [ALPHA-1:0]  hist_vld_reg, hist_vld_next;
    logic [BIN_W-1:0]  ref_idx_reg, ref_idx_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic [BIN_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              cmp_en_reg, cmp_en_next;
    logic [BIN_W-1:0]  cmp_bin_reg, cmp_bin_next;
    logic [HIST_W-1:0] best_cnt_reg, best_cnt_next;
    logic [BIN_W-1:0]  best_bin_reg, best_bin_next;
    logic [LEN_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_char_reg, m_char_next;
    logic [STAT_W-1:0] m_stat_reg, m_stat_next;
    logic              m_last_reg, m_last_next;

    // memories
    logic [BIN_W-1:0]  cipher_mem [MAX_LEN];
    logic [BIN_W-1:0]  cipher_q_reg;
    logic [HIST_W-1:0] hist_mem [ALPHA];
    logic [HIST_W-1:0] hist_q_reg;
    logic              hist_qv_reg;

    logic              cipher_we, cipher_re;
    logic [ADDR_W-1:0] cipher_wa, cipher_ra;
    logic [BIN_W-1:0]  cipher_wd;
    logic              hist_we, hist_re;
    logic [BIN_W-1:0]  hist_wa, hist_ra;
    logic [HIST_W-1:0] hist_wd;

    logic              out_free, out_load, run_clear;
    logic              run_err_len, run_err;
    logic              ref_vote, emit_last;
    logic [HIST_W-1:0] hist_val;
    logic [BIN_W-1:0]  ref_bin, out_bin;

    assign out_free    = !m_valid_reg || m_tready;
    assign run_err_len = ovf_reg || (cipher_len_reg == '0) || (cipher_len_reg != ref_len_reg);
    assign run_err     = run_err_len || bad_reg;
    assign ref_vote    = (ref_len_reg < LEN_W'(MAX_LEN)) && q_cmd.is_letter &&
                         (ref_len_reg < cipher_len_reg);
    assign emit_last   = (LEN_W'(emit_cnt_reg + 1'b1) == cipher_len_reg);
    assign hist_val    = hist_qv_reg ? hist_q_reg : '0;
    assign ref_bin     = mod_alpha({1'b0, ref_idx_reg} + (BIN_W+1)'(ALPHA) - {1'b0, cipher_q_reg});
    assign out_bin     = mod_alpha({1'b0, cipher_q_reg} + {1'b0, best_bin_reg});

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tuser  = m_stat_reg;
    assign m_tlast  = m_last_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid && (q_cmd.func == FN_END)) begin
                    state_next = BK_END;
                end else if (q_valid && (q_cmd.func == FN_REF) && ref_vote) begin
                    state_next = BK_REF_HIST;
                end
            end
            BK_REF_HIST: state_next = BK_REF_WR;
            BK_REF_WR:   state_next = BK_IDLE;
            BK_END: begin
                if (!run_err) begin
                    state_next = BK_SCAN;
                end else if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            BK_SCAN: begin
                if (scan_cnt_reg == SCAN_DONE) begin
                    state_next = BK_EMIT_RD;
                end
            end
            BK_EMIT_RD:  state_next = BK_EMIT_OUT;
            BK_EMIT_OUT: begin
                if (out_free) begin
                    state_next = emit_last ? BK_IDLE : BK_EMIT_RD;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        cipher_len_next = cipher_len_reg;
        ref_len_next    = ref_len_reg;
        bad_next        = bad_reg;
        ovf_next        = ovf_reg;
        hist_vld_next   = hist_vld_reg;
        ref_idx_next    = ref_idx_reg;
        bin_next        = bin_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_en_next     = 1'b0;
        cmp_bin_next    = cmp_bin_reg;
        best_cnt_next   = best_cnt_reg;
        best_bin_next   = best_bin_reg;
        emit_cnt_next   = emit_cnt_reg;
        m_char_next     = m_char_reg;
        m_stat_next     = m_stat_reg;
        m_last_next     = m_last_reg;
        q_pop           = 1'b0;
        cipher_we       = 1'b0;
        cipher_wa       = cipher_len_reg[ADDR_W-1:0];
        cipher_wd       = q_cmd.is_letter ? q_cmd.idx : '0;
        cipher_re       = 1'b0;
        cipher_ra       = emit_cnt_reg[ADDR_W-1:0];
        hist_we         = 1'b0;
        hist_wa         = bin_reg;
        hist_wd         = hist_val + 1'b1;
        hist_re         = 1'b0;
        hist_ra         = ref_bin;
        out_load        = 1'b0;
        run_clear       = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    unique case (q_cmd.func)
                        FN_CIPHER: begin
                            if (cipher_len_reg >= LEN_W'(MAX_LEN)) begin
                                ovf_next = 1'b1;
                            end else begin
                                cipher_we       = 1'b1;
                                cipher_len_next = cipher_len_reg + 1'b1;
                                if (!q_cmd.is_letter) begin
                                    bad_next = 1'b1;
                                end
                            end
                        end
                        FN_REF: begin
                            if (ref_len_reg >= LEN_W'(MAX_LEN)) begin
                                ovf_next = 1'b1;
                            end else begin
                                ref_len_next = ref_len_reg + 1'b1;
                                if (!q_cmd.is_letter) begin
                                    bad_next = 1'b1;
                                end
                                // vote only for a reference letter that has a cipher character at its position
                                if (ref_vote) begin
                                    cipher_re    = 1'b1;
                                    cipher_ra    = ref_len_reg[ADDR_W-1:0];
                                    ref_idx_next = q_cmd.idx;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_REF_HIST: begin
                hist_re  = 1'b1;
                hist_ra  = ref_bin;
                bin_next = ref_bin;
            end
            BK_REF_WR: begin
                if (hist_val < HIST_SAT) begin
                    hist_we                = 1'b1;
                    hist_vld_next[bin_reg] = 1'b1;
                end
            end
            BK_END: begin
                scan_cnt_next = '0;
                best_cnt_next = '0;
                best_bin_next = '0;
                emit_cnt_next = '0;
                if (run_err && out_free) begin
                    out_load    = 1'b1;
                    run_clear   = 1'b1;
                    m_char_next = '0;
                    m_stat_next = run_err_len ? STAT_LENGTH : STAT_BAD_CHAR;
                    m_last_next = 1'b1;
                end
            end
            BK_SCAN: begin
                // compare the bin read last cycle; strict > keeps the smallest shift
                if (cmp_en_reg && (hist_val > best_cnt_reg)) begin
                    best_cnt_next = hist_val;
                    best_bin_next = cmp_bin_reg;
                end
                // shifts 1..52 map to bins 1..51 then 0
                if (scan_cnt_reg != SCAN_DONE) begin
                    hist_re       = 1'b1;
                    hist_ra       = (scan_cnt_reg == BIN_LAST) ? '0 : scan_cnt_reg + 1'b1;
                    cmp_en_next   = 1'b1;
                    cmp_bin_next  = hist_ra;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            BK_EMIT_RD: begin
                cipher_re = 1'b1;
                cipher_ra = emit_cnt_reg[ADDR_W-1:0];
            end
            BK_EMIT_OUT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_char_next   = index_char(out_bin);
                    m_stat_next   = STAT_OK;
                    m_last_next   = emit_last;
                    emit_cnt_next = emit_cnt_reg + 1'b1;
                    run_clear     = emit_last;
                end
            end
            default: begin
            end
        endcase

        if (run_clear) begin
            cipher_len_next = '0;
            ref_len_next    = '0;
            bad_next        = 1'b0;
            ovf_next        = 1'b0;
            hist_vld_next   = '0;
        end

        m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            cipher_len_reg <= '0;
            ref_len_reg    <= '0;
            bad_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            hist_vld_reg   <= '0;
            cmp_en_reg     <= 1'b0;
            scan_cnt_reg   <= '0;
            emit_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cipher_len_reg <= cipher_len_next;
            ref_len_reg    <= ref_len_next;
            bad_reg        <= bad_next;
            ovf_reg        <= ovf_next;
            hist_vld_reg   <= hist_vld_next;
            cmp_en_reg     <= cmp_en_next;
            scan_cnt_reg   <= scan_cnt_next;
            emit_cnt_reg   <= emit_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ref_idx_reg  <= ref_idx_next;
        bin_reg      <= bin_next;
        cmp_bin_reg  <= cmp_bin_next;
        best_cnt_reg <= best_cnt_next;
        best_bin_reg <= best_bin_next;
        m_char_reg   <= m_char_next;
        m_stat_reg   <= m_stat_next;
        m_last_reg   <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (cipher_we) begin
            cipher_mem[cipher_wa] <= cipher_wd;
        end
        if (cipher_re) begin
            cipher_q_reg <= cipher_mem[cipher_ra];
        end
    end

    // bins never written since the last clear read as zero via hist_vld_reg
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_wa] <= hist_wd;
        end
        if (hist_re) begin
            hist_q_reg  <= hist_mem[hist_ra];
            hist_qv_reg <= hist_vld_reg[hist_ra];
        end
    end

    a_hist_wr_only_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_we |-> (state_reg == BK_REF_WR))
        else $error("histogram written outside the update step");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cipher_len_reg <= LEN_W'(MAX_LEN)) && (ref_len_reg <= LEN_W'(MAX_LEN)))
        else $error("length counter past MAX_LEN");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("pending result overwritten");

    a_clear_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        run_clear |=> ((cipher_len_reg == '0) && (ref_len_reg == '0) && (hist_vld_reg == '0)))
        else $error("run state not cleared after end");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> ((state_reg == BK_IDLE) && q_valid))
        else $error("command taken while engine busy");

endmodule

>>> rtl/caesar_shift_best_match_decoder_top.sv
// Top level of the Caesar shift search decoder.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_*): one word per command. s_tuser carries the command
//   (load cipher char, load reference char, end and decode), s_tdata the
//   ASCII character. Load cipher text first, then the reference text, then
//   send end. Code 3 is taken and ignored.
//   Output stream (m_*): after end, either one status word (m_tuser nonzero,
//   m_tdata zero, m_tlast high) or the decoded text, one letter per word,
//   m_tlast on the final letter.
//   Front end classifies each word into a small command queue; s_tready is
//   low only while that queue is full.
//   Engine steps per command: a cipher or reference load is taken in the idle
//   state; a vote adds a store read, a bin read and a bin write. An end with
//   an error loads its status word; an end with a decode runs the histogram
//   scan (one bin read per cycle, one compare stage), then a store read and an
//   output step per letter through the single read port of the cipher store.
//   Each word is written into the queue before the engine can see it.
//   Reset clears the queue, counts, flags and histogram at once; there is no
//   clearing pass. A stall on m_tready holds the result register and the
//   engine waits on it; the queue keeps taking input until it fills.
module caesar_shift_best_match_decoder_top import csbm_pkg::*; #(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // [7:0] in_char
    input  logic [FUNC_W-1:0] s_tuser,   // [1:0] func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,   // [7:0] out_char
    output logic [STAT_W-1:0] m_tuser,   // [1:0] status
    output logic              m_tlast
);

    logic q_full, q_push, q_valid, q_pop;
    cmd_t q_in_cmd, q_out_cmd;

    // classify and enqueue
    csbm_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in_cmd)
    );

    // decouples input acceptance from the engine
    csbm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (q_out_cmd)
    );

    // store, vote, scan, emit
    csbm_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_out_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> tb/caesar_shift_best_match_decoder_top_tb.sv
// Self-checking testbench for the Caesar shift search decoder top level.
`timescale 1ns / 1ps

module caesar_shift_best_match_decoder_top_tb;
    import csbm_pkg::*;

    localparam int          TEXT_MAX    = MAX_LEN_DEF;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          TAIL_CYCLES = 300;   // tail wait, longer than the scan and emit of a full-length text
    localparam int          ITEM_TARGET = 170;   // input words to cover over the directed part and the random runs
    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;   // unused code, dropped by the block

    // idling modes
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [STAT_W-1:0] status;
        logic              last;
    } decoded_t;

    // Shadow of the decoder: cipher store, vote bins, counts and flags, plus
    // the queue of letters/status words still owed by the block.
    class shift_decode_board;
        logic [BIN_W-1:0]  cipher_idx [TEXT_MAX];
        logic [HIST_W-1:0] votes [ALPHA];
        int unsigned       cipher_len, ref_len;
        bit                bad_seen, ovf_seen;
        decoded_t          owed [$];
        int unsigned       words_noted, texts_ok, status_runs, results_seen, errors;

        function new();
            foreach (cipher_idx[i]) cipher_idx[i] = '0;
            clear_run();
        endfunction

        function void clear_run();
            foreach (votes[i]) votes[i] = '0;
            cipher_len = 0;
            ref_len    = 0;
            bad_seen   = 1'b0;
            ovf_seen   = 1'b0;
        endfunction

        // letter index 0..51, or -1 for anything else
        function int to_index(logic [CHAR_W-1:0] c);
            if (c >= CHR_UA && c <= CHR_UZ) return int'(c - CHR_UA);
            if (c >= CHR_LA && c <= CHR_LZ) return int'(c - CHR_LA) + 26;
            return -1;
        endfunction

        function logic [CHAR_W-1:0] to_char(int k);
            return (k < 26) ? CHR_UA + CHAR_W'(k) : CHR_LA + CHAR_W'(k - 26);
        endfunction

        function void owe(logic [CHAR_W-1:0] c, logic [STAT_W-1:0] st, logic lst);
            decoded_t d;
            d.ch = c; d.status = st; d.last = lst;
            owed.push_back(d);
        endfunction

        // one accepted input word
        function void note_word(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] c);
            int li, pos, best_bin, best_cnt, b;
            li = to_index(c);
            if (f != FN_SPARE) words_noted++;
            case (f)
                FN_CIPHER: begin
                    if (cipher_len >= TEXT_MAX) begin
                        ovf_seen = 1'b1;
                    end else begin
                        if (li < 0) bad_seen = 1'b1;
                        cipher_idx[cipher_len] = (li < 0) ? '0 : BIN_W'(li);
                        cipher_len++;
                    end
                end
                FN_REF: begin
                    if (ref_len >= TEXT_MAX) begin
                        ovf_seen = 1'b1;
                    end else begin
                        pos = ref_len;
                        ref_len++;
                        if (li < 0) begin
                            bad_seen = 1'b1;
                        end else if (pos < cipher_len) begin
                            b = (li + ALPHA - int'(cipher_idx[pos])) % ALPHA;
                            if (votes[b] < HIST_SAT) votes[b]++;
                        end
                    end
                end
                FN_END: begin
                    if (ovf_seen || cipher_len == 0 || cipher_len != ref_len) begin
                        owe('0, STAT_LENGTH, 1'b1);
                        status_runs++;
                    end else if (bad_seen) begin
                        owe('0, STAT_BAD_CHAR, 1'b1);
                        status_runs++;
                    end else begin
                        // shifts 1..52 in order, 52 lives in bin 0; strict > keeps the smallest
                        best_bin = 0;
                        best_cnt = 0;
                        for (int s = 1; s <= ALPHA; s++) begin
                            b = s % ALPHA;
                            if (votes[b] > best_cnt) begin
                                best_cnt = votes[b];
                                best_bin = b;
                            end
                        end
                        for (int k = 0; k < cipher_len; k++)
                            owe(to_char((int'(cipher_idx[k]) + best_bin) % ALPHA), STAT_OK,
                                k + 1 == cipher_len);
                        texts_ok++;
                    end
                    clear_run();
                end
                default: ;   // spare code: no effect
            endcase
        endfunction

        // one accepted output word
        function void check_word(logic [CHAR_W-1:0] c, logic [STAT_W-1:0] st, logic lst);
            decoded_t e;
            results_seen++;
            if (owed.size() == 0) begin
                $display("%0t: unexpected word char %h status %0d last %0b", $time, c, st, lst);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (c !== e.ch) begin
                $display("%0t: char mismatch exp %h got %h", $time, e.ch, c);
                errors++;
            end
            if (st !== e.status) begin
                $display("%0t: status mismatch exp %0d got %0d", $time, e.status, st);
                errors++;
            end
            if (lst !== e.last) begin
                $display("%0t: last mismatch exp %0b got %0b", $time, e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0] s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [CHAR_W-1:0] m_tdata;
    logic [STAT_W-1:0] m_tuser;
    logic              m_tlast;

    shift_decode_board sb = new();
    int                idle_mode = IDLE_NONE;
    int unsigned       cycles = 0;
    int                run_no = 0;

    caesar_shift_best_match_decoder_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic bit sender_idle();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 81;
            IDLE_BOTH: return $urandom_range(0, 99) < 35;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(0, 99) < 81;
            IDLE_BOTH: return $urandom_range(0, 99) < 35;
            default:   return 1'b0;
        endcase
    endfunction

    // Result side: check at the edge, then pick the next m_tready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tuser, m_tlast);
        m_tready <= !receiver_stall();
    end

    // One word on the input stream; s_tvalid stays high into the next word
    // unless that word starts with a gap.
    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c);
        if (sender_idle()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (sender_idle()) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(f, c);
    endtask

    task automatic send_text(input logic [FUNC_W-1:0] f, input string txt);
        for (int i = 0; i < txt.len(); i++) send_word(f, txt[i]);
    endtask

    // hold the input until the block has delivered everything owed
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.owed.size() != 0) @(posedge aclk);
    endtask

    // occasional spare-code word between real ones
    task automatic maybe_spare();
        if ($urandom_range(0, 99) < 3) send_word(FN_SPARE, CHAR_W'($urandom_range(0, 255)));
    endtask

    function automatic logic [CHAR_W-1:0] rand_letter();
        return sb.to_char($urandom_range(0, ALPHA - 1));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_non_letter();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(0, 255)); while (sb.to_index(c) >= 0);
        return c;
    endfunction

    // One random run: mostly well-formed texts with a hidden shift and some
    // noisy reference letters, the rest broken on purpose.
    task automatic run_random(input bit full_len);
        logic [CHAR_W-1:0] ctext [TEXT_MAX + 2];
        logic [CHAR_W-1:0] rtext [TEXT_MAX + 2];
        int kind, n, nref, shift, ci;
        kind  = full_len ? 0 : $urandom_range(0, 99);
        n     = full_len ? TEXT_MAX : $urandom_range(1, 12);
        nref  = n;
        shift = $urandom_range(0, ALPHA - 1);
        for (int k = 0; k < TEXT_MAX + 2; k++) begin
            ci       = $urandom_range(0, ALPHA - 1);
            ctext[k] = sb.to_char(ci);
            rtext[k] = ($urandom_range(0, 99) < 20) ? rand_letter()
                                                    : sb.to_char((ci + shift) % ALPHA);
        end
        if (kind >= 70 && kind < 78) begin
            // one non-letter in either text
            if ($urandom_range(0, 1)) ctext[$urandom_range(0, n - 1)] = rand_non_letter();
            else                      rtext[$urandom_range(0, n - 1)] = rand_non_letter();
        end else if (kind >= 78 && kind < 86) begin
            nref = ($urandom_range(0, 1) && n > 1) ? n - 1 : n + 1;
            if (nref > TEXT_MAX) nref = TEXT_MAX + 1;
        end else if (kind >= 86 && kind < 89) begin
            // past the store size on one side
            n = TEXT_MAX;
            if ($urandom_range(0, 1)) n    = TEXT_MAX + $urandom_range(1, 2);
            else                      nref = TEXT_MAX + 1;
            if (nref < n) nref = TEXT_MAX;
        end else if (kind >= 89 && kind < 94) begin
            n    = 0;
            nref = $urandom_range(0, 3);
        end
        if (kind >= 94) begin
            // raw noise: any code, any byte
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
                send_word(FUNC_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)));
        end else begin
            for (int k = 0; k < n; k++) begin
                maybe_spare();
                send_word(FN_CIPHER, ctext[k]);
            end
            for (int k = 0; k < nref; k++) begin
                maybe_spare();
                send_word(FN_REF, rtext[k]);
            end
        end
        send_word(FN_END, CHAR_W'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty text
        send_word(FN_END, 8'h00);
        // shift 51 (largest) and the identity
        send_text(FN_CIPHER, "A"); send_text(FN_REF, "z"); send_word(FN_END, 8'hFF);
        send_text(FN_CIPHER, "z"); send_text(FN_REF, "z"); send_word(FN_END, 8'h00);
        // non-letters at both byte extremes and just below the lower-case range
        send_word(FN_CIPHER, 8'hFF); send_word(FN_CIPHER, 8'h00);
        send_text(FN_REF, "A"); send_word(FN_REF, 8'h60);
        send_word(FN_END, 8'h00);
        // length mismatch
        send_text(FN_CIPHER, "Za"); send_text(FN_REF, "A"); send_word(FN_END, 8'h00);
        // spare code is dropped
        send_word(FN_SPARE, 8'h80);
        // reference ahead of the cipher casts no vote: text comes out unshifted
        send_text(FN_REF, "Q"); send_text(FN_CIPHER, "M"); send_word(FN_END, 8'h00);
        // tie between shifts 1 and 2 goes to shift 1
        send_text(FN_CIPHER, "AA"); send_text(FN_REF, "BC"); send_word(FN_END, 8'h00);
        wait_drained();

        // random runs; each run drains first and takes the next idling mode
        while ((sb.words_noted < ITEM_TARGET) || (run_no < 4)) begin
            wait_drained();
            idle_mode = run_no % 4;
            run_random(run_no == 1);
            run_no++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.owed.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, sb.owed.size());
            sb.errors++;
        end

        $display("Covered %0d input words in %0d random runs under four idling modes;",
                 sb.words_noted, run_no);
        $display("%0d texts decoded, %0d status reports, %0d output words checked.",
                 sb.texts_ok, sb.status_runs, sb.results_seen);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/csbm_pkg.sv
rtl/csbm_front.sv
rtl/csbm_fifo.sv
rtl/csbm_back.sv
rtl/caesar_shift_best_match_decoder_top.sv
tb/caesar_shift_best_match_decoder_top_tb.sv
